// File: sv/nth_weekday_of_month_core_defines.svh
// Assertion macros shared by the nth weekday of month RTL.
`ifndef NTH_WEEKDAY_OF_MONTH_CORE_DEFINES_SVH
`define NTH_WEEKDAY_OF_MONTH_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NWM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nth weekday of month: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define NWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nth weekday of month: next-cycle check failed");

`endif

// File: sv/nwm_pkg.sv
// Package with codes, calendar tables and small arithmetic helpers for the block.
package nwm_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int CODE_W  = 3;
    localparam int DAY_W   = 5;
    localparam int YY_W    = 15;
    localparam int PROD_W  = 27;
    localparam int QUOT_W  = 8;

    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          RECIP_SHFT = 19;
    localparam logic [8:0]  CYCLE_400  = 9'd400;
    localparam logic [6:0]  CENTURY    = 7'd100;
    localparam logic [2:0]  WEEKDAY_MAX = 3'd6;

    typedef enum logic [CODE_W-1:0] {
        WEEK_FIRST  = 3'd0,
        WEEK_SECOND = 3'd1,
        WEEK_THIRD  = 3'd2,
        WEEK_FOURTH = 3'd3,
        WEEK_FIFTH  = 3'd4,
        WEEK_TEENTH = 3'd5,
        WEEK_LAST   = 3'd6
    } week_code_t;

    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd2;
            4'd4:    r = 3'd5;
            4'd5:    r = 3'd0;
            4'd6:    r = 3'd3;
            4'd7:    r = 3'd5;
            4'd8:    r = 3'd1;
            4'd9:    r = 3'd4;
            4'd10:   r = 3'd6;
            4'd11:   r = 3'd2;
            4'd12:   r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                    r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            default:                 r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] week_start(input logic [CODE_W-1:0] w);
        logic [DAY_W-1:0] r;
        case (w)
            WEEK_FIRST:  r = 5'd1;
            WEEK_SECOND: r = 5'd8;
            WEEK_THIRD:  r = 5'd15;
            WEEK_FOURTH: r = 5'd22;
            WEEK_FIFTH:  r = 5'd29;
            WEEK_TEENTH: r = 5'd13;
            default:     r = 5'd0;
        endcase
        return r;
    endfunction

    // Since eight is one more than seven, summing octal digits keeps the residue.
    function automatic logic [2:0] mod7_6(input logic [5:0] a);
        logic [3:0] t;
        logic [2:0] r;
        t = {1'b0, a[5:3]} + {1'b0, a[2:0]};
        if (t >= 4'd14) begin
            r = 3'd0;
        end else if (t >= 4'd7) begin
            r = 3'(t - 4'd7);
        end else begin
            r = t[2:0];
        end
        return r;
    endfunction

    function automatic logic [2:0] mod7_15(input logic [YY_W-1:0] a);
        logic [5:0] s;
        s = {3'b0, a[14:12]} + {3'b0, a[11:9]} + {3'b0, a[8:6]}
          + {3'b0, a[5:3]} + {3'b0, a[2:0]};
        return mod7_6(s);
    endfunction

    // Difference of two weekdays, wrapped into the range zero to six.
    function automatic logic [2:0] sub7(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] t;
        if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
        end else begin
            t = {1'b0, a} + 4'd7 - {1'b0, b};
        end
        return t[2:0];
    endfunction

endpackage

// File: sv/nth_weekday_of_month_core.sv
// Top level: four-stage pipeline that finds the nth weekday of a Gregorian month.
//
// A query (year, month, week_code, weekday_code) is taken on the input channel
// with in_valid and in_ready; the answer (day_of_month, found) leaves on the
// output channel with out_valid and out_ready. week_code selects first to fifth,
// teenth or last. When no such day lies in the month, or the month or a code
// is out of range, day_of_month is 0 and found is low.
// The result passes through the stage one, two and three registers and the
// output register before its output transfer. While out_ready stays high,
// the pipeline takes one query per cycle, so throughput is one transfer per
// cycle; stage one holds the reciprocal multiplies for the century divisions,
// stage two the weekday sum and leap test, stage three the reduction modulo
// seven, stage four the day selection and the output register.
// Reset clears every valid bit; the pipeline is empty afterwards.
// When the receiver holds out_ready low, each stage keeps its item until the
// stage after it is free, and in_ready falls once all four stages are full.
// Nothing is dropped or repeated, and bubbles are squeezed out while stalled.
`include "nth_weekday_of_month_core_defines.svh"

module nth_weekday_of_month_core
    import nwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [YEAR_W-1:0]   year,
    input  logic [MONTH_W-1:0]  month,
    input  logic [CODE_W-1:0]   week_code,
    input  logic [CODE_W-1:0]   weekday_code,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DAY_W-1:0]    day_of_month,
    output logic                found
);

    logic en1, en2, en3, en4;

    logic                s1_valid_reg;
    logic [YEAR_W-1:0]   s1_year_reg;
    logic [MONTH_W-1:0]  s1_month_reg;
    logic [CODE_W-1:0]   s1_week_reg;
    logic [CODE_W-1:0]   s1_want_reg;
    logic                s1_ok_reg;
    logic [YY_W-1:0]     s1_yy_reg;
    logic [PROD_W-1:0]   s1_py_reg;
    logic [PROD_W-1:0]   s1_pr_reg;

    logic                s2_valid_reg;
    logic [CODE_W-1:0]   s2_week_reg;
    logic [CODE_W-1:0]   s2_want_reg;
    logic                s2_ok_reg;
    logic [YY_W-1:0]     s2_sum_reg;
    logic [DAY_W-1:0]    s2_len_reg;

    logic                s3_valid_reg;
    logic [CODE_W-1:0]   s3_week_reg;
    logic [CODE_W-1:0]   s3_want_reg;
    logic                s3_ok_reg;
    logic [2:0]          s3_w0_reg;
    logic [DAY_W-1:0]    s3_len_reg;

    logic                out_valid_reg;
    logic [DAY_W-1:0]    day_reg;
    logic                found_reg;

    logic [YY_W-1:0]     yy_next;
    logic                ok_next;
    logic [QUOT_W-1:0]   qy;
    logic [QUOT_W-1:0]   qr;
    logic [YY_W-1:0]     century_base;
    logic                leap;
    logic [YY_W-1:0]     sum_next;
    logic [DAY_W-1:0]    start_day;
    logic [2:0]          wl;
    logic [2:0]          ws;
    logic [DAY_W:0]      cand;
    logic [DAY_W-1:0]    day_next;
    logic                found_next;

    assign en4      = !out_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    // Stage one: shifted year and reciprocal products for the divisions by 100.
    always_comb
    begin
        yy_next = {1'b0, year} + {6'b0, CYCLE_400} - ((month < 4'd3) ? 15'd1 : 15'd0);
        ok_next = (month >= 4'd1) && (month <= 4'd12)
               && (week_code <= WEEK_LAST) && (weekday_code <= WEEKDAY_MAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (en1) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid) begin
            s1_year_reg  <= year;
            s1_month_reg <= month;
            s1_week_reg  <= week_code;
            s1_want_reg  <= weekday_code;
            s1_ok_reg    <= ok_next;
            s1_yy_reg    <= yy_next;
            s1_py_reg    <= PROD_W'(yy_next * RECIP_100);
            s1_pr_reg    <= PROD_W'({1'b0, year} * RECIP_100);
        end
    end

    // Stage two: weekday sum of day zero and the leap-year test.
    always_comb
    begin
        qy           = s1_py_reg[RECIP_SHFT +: QUOT_W];
        qr           = s1_pr_reg[RECIP_SHFT +: QUOT_W];
        century_base = YY_W'(qr * CENTURY);
        leap         = (s1_year_reg[1:0] == 2'b00)
                    && (({1'b0, s1_year_reg} != century_base) || (qr[1:0] == 2'b00));
        sum_next     = s1_yy_reg + {2'b0, s1_yy_reg[YY_W-1:2]}
                     - {7'b0, qy} + {9'b0, qy[QUOT_W-1:2]}
                     + {12'b0, month_offset(s1_month_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end else if (en2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg) begin
            s2_week_reg <= s1_week_reg;
            s2_want_reg <= s1_want_reg;
            s2_ok_reg   <= s1_ok_reg;
            s2_sum_reg  <= sum_next;
            s2_len_reg  <= month_length(s1_month_reg, leap);
        end
    end

    // Stage three: weekday of day zero of the month.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s3_valid_reg <= 1'b0;
        end else if (en3) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg) begin
            s3_week_reg <= s2_week_reg;
            s3_want_reg <= s2_want_reg;
            s3_ok_reg   <= s2_ok_reg;
            s3_w0_reg   <= mod7_15(s2_sum_reg);
            s3_len_reg  <= s2_len_reg;
        end
    end

    // Stage four: forward search from the start day or backward from the last day.
    always_comb
    begin
        start_day  = week_start(s3_week_reg);
        wl         = mod7_6({1'b0, s3_len_reg} + {3'b0, s3_w0_reg});
        ws         = mod7_6({1'b0, start_day} + {3'b0, s3_w0_reg});
        cand       = {1'b0, start_day} + {3'b0, sub7(s3_want_reg, ws)};
        day_next   = '0;
        found_next = 1'b0;
        if (s3_ok_reg) begin
            if (s3_week_reg == WEEK_LAST) begin
                day_next   = s3_len_reg - {2'b0, sub7(wl, s3_want_reg)};
                found_next = 1'b1;
            end else if (cand <= {1'b0, s3_len_reg}) begin
                day_next   = cand[DAY_W-1:0];
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (en4) begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && s3_valid_reg) begin
            day_reg   <= day_next;
            found_reg <= found_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign day_of_month = day_reg;
    assign found        = found_reg;

    `NWM_ASSERT_SAME(a_none_is_zero, clk, rst_n, out_valid_reg && !found_reg, day_reg == '0)
    `NWM_ASSERT_NEXT(a_bad_code_not_found, clk, rst_n,
                     s3_valid_reg && en4 && !s3_ok_reg, !found_reg)
    `NWM_ASSERT_NEXT(a_last_always_found, clk, rst_n,
                     s3_valid_reg && en4 && s3_ok_reg && (s3_week_reg == WEEK_LAST),
                     found_reg && (day_reg > 5'd21))

endmodule

// File: bench/nwm_checker.sv
// Checker that predicts each meetup-day answer and compares it with the block's output.
`timescale 1ns / 100ps

module nwm_checker
    import nwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [CODE_W-1:0]  week_code,
    input  logic [CODE_W-1:0]  weekday_code,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [DAY_W-1:0]   day_of_month,
    input  logic               found,
    output int                 errors,
    output int                 pending,
    output int                 checked,
    output int                 hits
);

    typedef struct packed {
        logic [DAY_W-1:0] day;
        logic             hit;
    } meetup_t;

    localparam int MONTH_SHIFT [1:12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    localparam int MONTH_DAYS  [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    meetup_t expected_days [$];

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int day_of_week(input int y, input int m, input int d);
        int yy;
        yy = y + 400;
        if (m < 3)
        begin
            yy = yy - 1;
        end
        return (yy + yy / 4 - yy / 100 + yy / 400 + MONTH_SHIFT[m] + d) % 7;
    endfunction

    function automatic meetup_t meetup_day(input logic [YEAR_W-1:0]  y,
                                           input logic [MONTH_W-1:0] m,
                                           input logic [CODE_W-1:0]  wk,
                                           input logic [CODE_W-1:0]  wd);
        meetup_t r;
        int      len;
        int      first;
        int      cand;
        r = '0;
        if (m < 1 || m > 12 || wk > WEEK_LAST || wd > WEEKDAY_MAX)
        begin
            return r;
        end
        len = MONTH_DAYS[m];
        if (m == 2 && leap_year(y))
        begin
            len = 29;
        end
        if (week_code_t'(wk) == WEEK_LAST)
        begin
            r.day = DAY_W'(len - ((day_of_week(y, m, len) + 7 - wd) % 7));
            r.hit = 1'b1;
            return r;
        end
        case (week_code_t'(wk))
            WEEK_FIRST:  first = 1;
            WEEK_SECOND: first = 8;
            WEEK_THIRD:  first = 15;
            WEEK_FOURTH: first = 22;
            WEEK_FIFTH:  first = 29;
            default:     first = 13;
        endcase
        cand = first + ((wd + 7 - day_of_week(y, m, first)) % 7);
        if (cand <= len)
        begin
            r.day = DAY_W'(cand);
            r.hit = 1'b1;
        end
        return r;
    endfunction

    initial
    begin
        errors  = 0;
        pending = 0;
        checked = 0;
        hits    = 0;
    end

    always @(posedge clk)
    begin
        meetup_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_days.push_back(meetup_day(year, month, week_code, weekday_code));
            end
            if (out_valid && out_ready)
            begin
                if (expected_days.size() == 0)
                begin
                    $error("Unexpected result transfer: day_of_month %0d, found %0d",
                           day_of_month, found);
                    errors++;
                end
                else
                begin
                    want = expected_days.pop_front();
                    checked++;
                    if (want.hit)
                    begin
                        hits++;
                    end
                    if (day_of_month !== want.day)
                    begin
                        $error("day_of_month: expected %0d, actual %0d", want.day,
                               day_of_month);
                        errors++;
                    end
                    if (found !== want.hit)
                    begin
                        $error("found: expected %0d, actual %0d", want.hit, found);
                        errors++;
                    end
                end
            end
            pending = expected_days.size();
        end
    end

endmodule

// File: bench/testbench.sv
// Top of the testbench: clock, reset, query stimulus, output back-pressure and verdict.
`timescale 1ns / 100ps

module testbench;
    import nwm_pkg::*;

    localparam int LIMIT        = 400000;
    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [CODE_W-1:0] SUNDAY      = 3'd0;
    localparam logic [CODE_W-1:0] MONDAY      = 3'd1;
    localparam logic [CODE_W-1:0] TUESDAY     = 3'd2;
    localparam logic [CODE_W-1:0] WEDNESDAY   = 3'd3;
    localparam logic [CODE_W-1:0] THURSDAY    = 3'd4;
    localparam logic [CODE_W-1:0] FRIDAY      = 3'd5;
    localparam logic [CODE_W-1:0] SATURDAY    = 3'd6;
    localparam logic [CODE_W-1:0] BAD_WEEKDAY = 3'd7;
    localparam logic [CODE_W-1:0] BAD_WEEK    = 3'd7;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [CODE_W-1:0]  week_code;
    logic [CODE_W-1:0]  weekday_code;
    logic               out_valid;
    logic               out_ready;
    logic [DAY_W-1:0]   day_of_month;
    logic               found;

    int errors;
    int pending;
    int checked;
    int hits;
    int cycles;
    int sent_count;
    int idle_mode;
    bit held;

    nth_weekday_of_month_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .year         (year),
        .month        (month),
        .week_code    (week_code),
        .weekday_code (weekday_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .day_of_month (day_of_month),
        .found        (found)
    );

    nwm_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .year         (year),
        .month        (month),
        .week_code    (week_code),
        .weekday_code (weekday_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .day_of_month (day_of_month),
        .found        (found),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked),
        .hits         (hits)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (idle_mode == 0)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_query(input logic [YEAR_W-1:0]  y,
                              input logic [MONTH_W-1:0] m,
                              input logic [CODE_W-1:0]  wk,
                              input logic [CODE_W-1:0]  wd);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        year         = y;
        month        = m;
        week_code    = wk;
        weekday_code = wd;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sent_count++;
        @(negedge clk);
    endtask

    initial
    begin
        int stall_left;
        int r;
        out_ready  = 1'b0;
        stall_left = 0;
        held       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sent_count >= HOLD_AFTER)
            begin
                held      = 1'b1;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready = 1'b1;
            end
            else if (idle_mode == 0)
            begin
                out_ready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_ready  = 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    out_ready = 1'b1;
                end
                else
                begin
                    out_ready  = 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                end
            end
        end
    end

    initial
    begin
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [CODE_W-1:0]  wk;
        logic [CODE_W-1:0]  wd;
        int                 r;
        cycles       = 0;
        sent_count   = 0;
        idle_mode    = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        year         = '0;
        month        = '0;
        week_code    = '0;
        weekday_code = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_query(2013, 5, WEEK_TEENTH, MONDAY);
        send_query(2000, 2, WEEK_LAST, TUESDAY);
        send_query(1900, 2, WEEK_LAST, WEDNESDAY);
        send_query(2024, 2, WEEK_FIFTH, THURSDAY);
        send_query(2023, 2, WEEK_FIFTH, WEDNESDAY);
        send_query(2100, 2, WEEK_FIFTH, SUNDAY);
        send_query(2012, 2, WEEK_FIFTH, WEDNESDAY);
        send_query(1583, 1, WEEK_FIRST, SUNDAY);
        send_query(9999, 12, WEEK_LAST, SATURDAY);
        send_query(0, 3, WEEK_SECOND, FRIDAY);
        send_query(16383, 1, WEEK_THIRD, MONDAY);
        send_query(2019, 11, WEEK_FOURTH, THURSDAY);
        send_query(2021, 4, WEEK_FIFTH, FRIDAY);
        send_query(2021, 0, WEEK_FIRST, MONDAY);
        send_query(2021, 13, WEEK_SECOND, TUESDAY);
        send_query(2021, 15, WEEK_LAST, SUNDAY);
        send_query(2021, 6, BAD_WEEK, MONDAY);
        send_query(2021, 6, WEEK_FIRST, BAD_WEEKDAY);
        send_query(14'h2AAA, 8, WEEK_SECOND, SATURDAY);
        send_query(14'h1555, 9, WEEK_THIRD, TUESDAY);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_mode = int'((i / 100) % 3 != 0);
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                y = YEAR_W'($urandom_range(1583, 9999));
            end
            else if (r < 80)
            begin
                y = YEAR_W'(100 * $urandom_range(16, 99));
            end
            else if (r < 88)
            begin
                y = YEAR_W'(4 * $urandom_range(396, 2499));
            end
            else
            begin
                y = YEAR_W'($urandom_range(0, 16383));
            end
            m  = MONTH_W'(($urandom_range(0, 99) < 90) ? $urandom_range(1, 12)
                                                       : $urandom_range(0, 15));
            wk = CODE_W'(($urandom_range(0, 99) < 93) ? $urandom_range(0, 6)
                                                      : $urandom_range(0, 7));
            wd = CODE_W'(($urandom_range(0, 99) < 93) ? $urandom_range(0, 6)
                                                      : $urandom_range(0, 7));
            send_query(y, m, wk, wd);
        end
        in_valid = 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run sent %0d queries and checked %0d answers, %0d of them inside the month.",
                 sent_count, checked, hits);
        $display("Covered all selectors, leap Februaries, missing fifth days, bad codes, ",
                 "random gaps and a long output hold-off.");
        if (errors == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/nwm_pkg.sv
sv/nth_weekday_of_month_core.sv
bench/nwm_checker.sv
bench/testbench.sv
